// ===== rtl/cspg_pkg.sv =====
// Package for the clamp step protocol generator: register indexes, phase codes, reset values.
`default_nettype none

package cspg_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 26;
  localparam int VOLT_W      = 12;
  localparam int COUNT_W     = 8;
  localparam int TICKS_W     = 26;
  localparam int PLEN_W      = 28;
  localparam int STEP_W      = 9;
  localparam int OUT_V_W     = 21;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESTEP_V = 3'd0,
    REG_START_V   = 3'd1,
    REG_FINISH_V  = 3'd2,
    REG_COUNT     = 3'd3,
    REG_PRESTEP_T = 3'd4,
    REG_TEST_T    = 3'd5,
    REG_PAUSE_T   = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_PAUSE    = 3'd0,
    PH_PRESTEP  = 3'd1,
    PH_TEST     = 3'd2,
    PH_BOUNDARY = 3'd3,
    PH_FINISHED = 3'd4
  } phase_e;

  localparam logic signed [VOLT_W-1:0] PRESTEP_V_RST = 12'sd50;
  localparam logic signed [VOLT_W-1:0] START_V_RST   = 12'sd50;
  localparam logic signed [VOLT_W-1:0] FINISH_V_RST  = -12'sd20;
  localparam logic [COUNT_W-1:0]       COUNT_RST     = 8'd15;
  localparam logic [TICKS_W-1:0]       PRESTEP_T_RST = 26'd1800000;
  localparam logic [TICKS_W-1:0]       TEST_T_RST    = 26'd50000;
  localparam logic [TICKS_W-1:0]       PAUSE_T_RST   = 26'd1800000;
  localparam logic [PLEN_W-1:0]        PLEN_RST      = 28'd3650000;

  localparam logic signed [OUT_V_W-1:0] OUT_V_MAX = 21'sd1048575;
  localparam logic signed [OUT_V_W-1:0] OUT_V_MIN = -21'sd1048576;

endpackage

`default_nettype wire

// ===== rtl/clamp_step_protocol_generator.sv =====
// Clamp step protocol generator: tick-driven command voltage sequencer with delta divider.
//
// Usage:
//   Slave stream s_axis: one request per sample tick; tdata[0] is the restart flag.
//   Master stream m_axis: one result per tick with the clamp command voltage,
//   the step number, the phase and the finished flag.
//   Config channel cfg_*: writes one protocol register per request.
// Result timing: a result is registered in the cycle after its tick is taken; one tick
//   per cycle is sustained while the divider is idle and results are read. The output
//   register frees itself when read, so a new tick is taken while a result is taken.
// Reset and config writes: the per-step voltage delta is divided out by a
//   one-bit-per-cycle restoring divider after reset and after each register
//   write (the difference is taken undivided when count is below two).
//   Both s_axis_tready and cfg_ready_o are low during that time. Delta, start
//   voltage and first period are latched at reset and on restart only.
// Stall: while m_axis_tready is low and a result is held, s_axis_tready is low
//   and the protocol state does not advance.
`default_nettype none

module clamp_step_protocol_generator
  import cspg_pkg::*;
#(
  parameter int AGE_WIDTH     = 36,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [0] restart, [7:1] zero
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [31:0]                m_axis_tdata,   // [20:0] clamp_voltage,
                                                     // [29:21] step_number, [31:30] zero
  output logic [3:0]                 m_axis_tuser,   // [2:0] phase, [3] finished
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int VW   = 13 + FRACTION_BITS;
  localparam int NW   = 12 + FRACTION_BITS;
  // step voltage has room for up to 255 deltas past the start level
  localparam int SVW  = VW + 8;
  localparam int SW   = ((AGE_WIDTH > PLEN_W) ? AGE_WIDTH : PLEN_W) + 1;
  localparam int CW   = ((SVW > OUT_V_W) ? SVW : OUT_V_W) + 1;
  localparam int CNTW = $clog2(NW + 1);

  localparam logic signed [SVW-1:0]   SV_RST  = SVW'(START_V_RST) <<< FRACTION_BITS;
  localparam logic [AGE_WIDTH-1:0]    PE_RST  = AGE_WIDTH'(PLEN_RST);
  localparam logic signed [CW-1:0]    SAT_MAX = CW'(OUT_V_MAX);
  localparam logic signed [CW-1:0]    SAT_MIN = CW'(OUT_V_MIN);

  function automatic logic [AGE_WIDTH-1:0] sat_age(input logic [SW-1:0] s);
    logic [AGE_WIDTH-1:0] r;
    r = (|s[SW-1:AGE_WIDTH]) ? {AGE_WIDTH{1'b1}} : s[AGE_WIDTH-1:0];
    return r;
  endfunction

  // configuration registers
  logic signed [VOLT_W-1:0] prestep_v_q, start_v_q, finish_v_q;
  logic [COUNT_W-1:0]       count_q;
  logic [TICKS_W-1:0]       prestep_t_q, test_t_q, pause_t_q;

  // protocol state
  logic [AGE_WIDTH-1:0]     age_q, age_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic [AGE_WIDTH-1:0]     pe_q, pe_d;
  logic signed [SVW-1:0]    sv_q, sv_d;
  logic signed [VW-1:0]     vd_q, vd_d;

  // divider
  logic                     start_q, run_q, pend_q;
  logic [CNTW-1:0]          cnt_q;
  logic [8:0]               rem_q, rem_d;
  logic [NW-1:0]            quo_q, quo_d;
  logic [COUNT_W-1:0]       dvs_q;
  logic                     neg_q;
  logic signed [VW-1:0]     delta_q;
  logic signed [VW-1:0]     diff;
  logic [NW-1:0]            diff_mag;
  logic [8:0]               rem_sh;
  logic                     rem_ge;
  logic                     div_busy, div_fin;
  logic signed [VW-1:0]     div_res;

  // output register
  logic                     m_valid_q;
  logic [31:0]              m_data_q;
  logic [3:0]               m_user_q;

  logic                     s_acc, cfg_acc, restart;
  logic [PLEN_W-1:0]        plen;
  logic [AGE_WIDTH-1:0]     age_c, pe_c;
  logic [STEP_W-1:0]        step_c;
  logic signed [SVW-1:0]    sv_c;
  logic signed [VW-1:0]     vd_c;
  logic                     active, bound;
  phase_e                   phase_c;
  logic signed [SVW-1:0]    volt_c;
  logic signed [CW-1:0]     volt_ext;
  logic signed [OUT_V_W-1:0] volt_sat;

  assign div_busy      = start_q | run_q;
  assign s_axis_tready = ~div_busy & (~m_valid_q | m_axis_tready);
  assign cfg_ready_o   = ~div_busy;
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign cfg_acc       = cfg_valid_i & cfg_ready_o;
  assign restart       = s_axis_tdata[0];
  assign plen          = PLEN_W'(pause_t_q) + PLEN_W'(prestep_t_q) + PLEN_W'(test_t_q);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prestep_v_q <= PRESTEP_V_RST;
      start_v_q   <= START_V_RST;
      finish_v_q  <= FINISH_V_RST;
      count_q     <= COUNT_RST;
      prestep_t_q <= PRESTEP_T_RST;
      test_t_q    <= TEST_T_RST;
      pause_t_q   <= PAUSE_T_RST;
    end else if (cfg_acc) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PRESTEP_V: prestep_v_q <= cfg_data_i[VOLT_W-1:0];
        REG_START_V:   start_v_q   <= cfg_data_i[VOLT_W-1:0];
        REG_FINISH_V:  finish_v_q  <= cfg_data_i[VOLT_W-1:0];
        REG_COUNT:     count_q     <= cfg_data_i[COUNT_W-1:0];
        REG_PRESTEP_T: prestep_t_q <= cfg_data_i;
        REG_TEST_T:    test_t_q    <= cfg_data_i;
        REG_PAUSE_T:   pause_t_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // delta = (finish - start) * 2^FB / (count - 1), truncated toward zero
  always_comb begin
    diff     = (VW'(finish_v_q) - VW'(start_v_q)) <<< FRACTION_BITS;
    diff_mag = diff[VW-1] ? NW'(-diff) : NW'(diff);
    rem_sh   = {rem_q[7:0], quo_q[NW-1]};
    rem_ge   = rem_sh >= {1'b0, dvs_q};
    rem_d    = rem_ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
    quo_d    = {quo_q[NW-2:0], rem_ge};
    div_fin  = (start_q & (count_q <= 8'd1)) | (run_q & (cnt_q == '0));
    if (start_q) begin
      div_res = diff;
    end else if (neg_q) begin
      div_res = -$signed({1'b0, quo_q});
    end else begin
      div_res = $signed({1'b0, quo_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      run_q   <= 1'b0;
      pend_q  <= 1'b1;
      cnt_q   <= '0;
    end else begin
      if (cfg_acc) begin
        start_q <= 1'b1;
      end else if (start_q) begin
        start_q <= 1'b0;
        run_q   <= (count_q > 8'd1);
        cnt_q   <= CNTW'(NW);
      end else if (run_q) begin
        if (cnt_q == '0) begin
          run_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
      if (div_fin) begin
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_q) begin
      rem_q <= '0;
      quo_q <= diff_mag;
      dvs_q <= count_q - 8'd1;
      neg_q <= diff[VW-1];
    end else if (run_q && (cnt_q != '0)) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (div_fin) begin
      delta_q <= div_res;
    end
  end

  // one tick
  always_comb begin
    if (restart) begin
      age_c  = '0;
      step_c = STEP_W'(1);
      pe_c   = sat_age(SW'(plen));
      sv_c   = SVW'(start_v_q) <<< FRACTION_BITS;
      vd_c   = delta_q;
    end else begin
      age_c  = age_q;
      step_c = step_q;
      pe_c   = pe_q;
      sv_c   = sv_q;
      vd_c   = vd_q;
    end
    active = step_c <= {1'b0, count_q};
    bound  = age_c >= pe_c;
    step_d = step_c;
    pe_d   = pe_c;
    sv_d   = sv_c;
    vd_d   = vd_c;
    age_d  = sat_age(SW'(age_c) + SW'(1));
    volt_c = '0;
    if (!active) begin
      phase_c = PH_FINISHED;
    end else if (bound) begin
      phase_c = PH_BOUNDARY;
      step_d  = step_c + STEP_W'(1);
      pe_d    = sat_age(SW'(pe_c) + SW'(plen));
      sv_d    = sv_c + SVW'(vd_c);
    end else if (SW'(age_c) + SW'(prestep_t_q) + SW'(test_t_q) < SW'(pe_c)) begin
      phase_c = PH_PAUSE;
    end else if (SW'(age_c) + SW'(test_t_q) < SW'(pe_c)) begin
      phase_c = PH_PRESTEP;
      volt_c  = SVW'(prestep_v_q) <<< FRACTION_BITS;
    end else begin
      phase_c = PH_TEST;
      volt_c  = sv_c;
    end
    volt_ext = CW'(volt_c);
    if (volt_ext > SAT_MAX) begin
      volt_sat = OUT_V_MAX;
    end else if (volt_ext < SAT_MIN) begin
      volt_sat = OUT_V_MIN;
    end else begin
      volt_sat = OUT_V_W'(volt_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q  <= '0;
      step_q <= STEP_W'(1);
      pe_q   <= PE_RST;
      sv_q   <= SV_RST;
    end else if (s_acc) begin
      age_q  <= age_d;
      step_q <= step_d;
      pe_q   <= pe_d;
      sv_q   <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      vd_q <= vd_d;
    end else if (div_fin && pend_q) begin
      vd_q <= div_res;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_acc) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      m_data_q <= {2'b00, step_c, volt_sat};
      m_user_q <= {~active, phase_c};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  a_no_tick_while_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_busy)
    else $error("tick taken while delta divider busy");

  a_cfg_restarts_divider: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc |=> start_q)
    else $error("config write did not restart divider");

  a_age_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !restart) |=> age_q >= $past(age_q))
    else $error("age went backward without restart");

  a_restart_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && restart) |=> (step_q == STEP_W'(1) || step_q == STEP_W'(2)))
    else $error("restart did not rewind step");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> m_axis_tvalid)
    else $error("accepted tick produced no result");

endmodule

`default_nettype wire
